// File: sv/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types, constants and helpers for the counting semaphore block.
// ----------------------------------------------------------------------------
package csem_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH    = 16;
  localparam int THREAD_ID_BITS = 8;
  localparam int PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W          = $clog2(QUEUE_DEPTH + 1);

  // Port field widths
  localparam int KIND_W   = 2;
  localparam int THREAD_W = 8;
  localparam int ACTION_W = 3;
  localparam int INIT_W   = 15;
  localparam int COUNT_W  = 16;

  // Count limits (16-bit two's complement)
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WAIT    = 2'd0,
    KIND_SIGNAL  = 2'd1,
    KIND_DESTROY = 2'd2
  } kind_e;

  // Result actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_GRANTED       = 3'd0,
    ACT_BLOCKED       = 3'd1,
    ACT_WOKEN         = 3'd2,
    ACT_NO_WAITER     = 3'd3,
    ACT_ERROR         = 3'd4,
    ACT_EMPTY_DESTROY = 3'd5
  } action_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // capture the input item
    logic step;   // produce one result and update state
  } csem_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic last;       // the pending result is the final one of the item
  } csem_sts_t;

  // Circular pointer advance for any queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

// File: sv/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Sequencing FSM: takes one item, steps the datapath until the item's last
// result has been handed to the output register.
// ----------------------------------------------------------------------------
module csem_ctrl import csem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  csem_sts_t sts_i,
  output csem_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Handshake and commands
  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.step = ((state_q == ST_EXEC) || (state_q == ST_DRAIN)) && sts_i.slot_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.slot_free) state_d = sts_i.last ? ST_IDLE : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.slot_free && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/csem_dp.sv
// ----------------------------------------------------------------------------
// csem_dp
// Semaphore datapath: count, waiter queue memory with pointers, initial-count
// register and the output result register.
// ----------------------------------------------------------------------------
module csem_dp import csem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [INIT_W-1:0]   cfg_wdata_i,
  // input item
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [THREAD_W-1:0] thread_id_i,
  // control
  input  csem_cmd_t           cmd_i,
  output csem_sts_t           sts_o,
  // result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ACTION_W-1:0] action_o,
  output logic [THREAD_W-1:0] woken_thread_o,
  output logic                destroyed_o,
  output logic                last_o
);

  // Configuration register
  logic [INIT_W-1:0] init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
    end
  end

  // Captured item
  logic [KIND_W-1:0]   kind_q;
  logic [THREAD_W-1:0] tid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      tid_q  <= thread_id_i;
    end
  end

  // Semaphore state
  logic signed [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]          head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic [THREAD_ID_BITS-1:0] rd_q;
  logic                      push;

  // Result fields for the current step
  logic [ACTION_W-1:0] res_action;
  logic [THREAD_W-1:0] res_thread;
  logic                res_destroyed;
  logic                res_last;

  logic q_full, q_empty;
  assign q_full  = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign q_empty = (occ_q == '0);

  // Result and next-state decode
  always_comb begin
    res_action    = ACT_ERROR;
    res_thread    = '0;
    res_destroyed = 1'b0;
    res_last      = 1'b1;
    count_d       = count_q;
    head_d        = head_q;
    tail_d        = tail_q;
    occ_d         = occ_q;
    push          = 1'b0;

    unique case (kind_q)
      KIND_WAIT: begin
        if (count_q <= 16'sd0) begin
          // would block: queue the caller unless full or at minimum count
          if (!(q_full || (count_q == COUNT_MIN))) begin
            res_action = ACT_BLOCKED;
            count_d    = count_q - 16'sd1;
            push       = 1'b1;
            tail_d     = ptr_inc(tail_q);
            occ_d      = occ_q + OCC_W'(1);
          end
        end else begin
          res_action = ACT_GRANTED;
          count_d    = count_q - 16'sd1;
        end
      end
      KIND_SIGNAL: begin
        if (count_q != COUNT_MAX) begin
          count_d = count_q + 16'sd1;
          if ((count_q < 16'sd0) && !q_empty) begin
            res_action = ACT_WOKEN;
            res_thread = THREAD_W'(rd_q);
            head_d     = ptr_inc(head_q);
            occ_d      = occ_q - OCC_W'(1);
          end else begin
            res_action = ACT_NO_WAITER;
          end
        end
      end
      KIND_DESTROY: begin
        if (q_empty) begin
          res_action = ACT_EMPTY_DESTROY;
        end else begin
          // release one waiter per step, oldest first
          res_action    = ACT_WOKEN;
          res_thread    = THREAD_W'(rd_q);
          res_destroyed = 1'b1;
          res_last      = (occ_q == OCC_W'(1));
          head_d        = ptr_inc(head_q);
          occ_d         = occ_q - OCC_W'(1);
        end
        if (res_last) begin
          head_d  = '0;
          tail_d  = '0;
          count_d = COUNT_W'({1'b0, init_q});
        end
      end
      default: begin
        res_action = ACT_ERROR;
      end
    endcase
  end

  // State registers, updated only on a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else if (cmd_i.step) begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
    end
  end

  // Waiter queue memory; read port follows the next head so that a drain
  // can release one waiter per cycle while the output register is free
  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]          rd_addr;

  assign rd_addr = cmd_i.step ? head_d : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && push) begin
      mem[tail_q] <= THREAD_ID_BITS'(tid_q);
    end
    rd_q <= mem[rd_addr];
  end

  // Output register
  logic                out_valid_q;
  logic [ACTION_W-1:0] action_q;
  logic [THREAD_W-1:0] woken_q;
  logic                destroyed_q;
  logic                last_q;

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last      = res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      action_q    <= res_action;
      woken_q     <= res_thread;
      destroyed_q <= res_destroyed;
      last_q      <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign woken_thread_o = woken_q;
  assign destroyed_o    = destroyed_q;
  assign last_o         = last_q;

endmodule

// File: sv/counting_semaphore_with_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_with_wait_queue
// Counting semaphore with a FIFO of blocked thread numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: kind_i selects
//   wait, signal or destroy, thread_id_i names the caller of a wait.
//   Output channel (out_valid_o/out_ready_i) returns result items: action,
//   woken thread, destroyed mark and a last flag on the item's final result.
//   Wait and signal give one result; destroy gives one result per queued
//   waiter (or one if the queue is empty), then reloads the count from the
//   initial-count register written through cfg_we_i/cfg_wdata_i.
//   Sequencing: an accepted item is captured in the item register, and its
//   results are then written to the output register, one per step. A new
//   item is taken only after the last result of the current one; a destroy
//   steps once per queued waiter, through the single read port of the queue.
//   Reset clears the count, queue pointers, occupancy and the initial-count
//   register; queue contents are left as they are.
//   A stalled receiver holds the result register; the block then waits and
//   stops taking new items once its current item needs the output register.
// ----------------------------------------------------------------------------
module counting_semaphore_with_wait_queue import csem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [INIT_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [THREAD_W-1:0] thread_id_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ACTION_W-1:0] action_o,
  output logic [THREAD_W-1:0] woken_thread_o,
  output logic                destroyed_o,
  output logic                last_o
);

  csem_cmd_t cmd;
  csem_sts_t sts;

  csem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csem_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .thread_id_i    (thread_id_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .woken_thread_o (woken_thread_o),
    .destroyed_o    (destroyed_o),
    .last_o         (last_o)
  );

endmodule
